// ===== rtl/core/ras_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_pkg
// Shared types and constants of the resizing array stack: item formats,
// command codes, controller states and the policy constants.
// ----------------------------------------------------------------------------
package ras_pkg;

  // Default physical depth of the stack memory.
  localparam int RAS_DEPTH = 1024;

  // Fixed field widths of the item formats.
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 11;
  localparam int CNT_OUT_W = 11;
  localparam int RESIZE_W  = 16;

  // Resize policy and reset constants.
  localparam int MIN_CAPACITY   = 2;
  localparam int RESET_CAPACITY = 10;
  localparam int SHRINK_FLOOR   = 10;

  // Word reported for a missing element.
  localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd99;

  // Command codes.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } ras_cmd_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } ras_state_e;

  // One input item.
  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] value;
  } ras_in_t;

  // One result item.
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic [CNT_OUT_W-1:0]     item_count;
    logic [CNT_OUT_W-1:0]     capacity;
    logic [CNT_OUT_W-1:0]     peak_capacity;
    logic [RESIZE_W-1:0]      resize_count;
    logic                     is_empty;
    logic                     is_full;
  } ras_out_t;

endpackage

// ===== rtl/core/resizing_array_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resizing_array_stack
// LIFO stack of 32-bit words in a synchronous memory, with a logical
// capacity that grows to seven quarters when full and halves when under
// half full, counting resizes and tracking the peak capacity.
//
//   Channel  Direction  Handshake                Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_data_i (initial capacity)
//   in       in         in_valid_i/in_ready_o    in_data_i (ras_in_t)
//   out      out        out_valid_o/out_ready_i  out_data_o (ras_out_t)
//
// A push goes through ST_IDLE and ST_DONE; a pop that leaves elements behind
// also goes through ST_READ, the registered read of the word below the popped top.
// Pushes, refusals and pops that empty the stack use the cached top word.
// Reset gives an empty stack with capacity 10; a configuration write loads
// the clamped capacity and empties the stack. The memory needs no clearing.
// A result waiting in the output register does not hold up the next item.
// ----------------------------------------------------------------------------
module resizing_array_stack
  import ras_pkg::*;
#(
  parameter int DEPTH = RAS_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ras_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ras_out_t         out_data_o
);

  localparam int AW = $clog2(DEPTH);

  logic              res_valid;
  logic              res_ready;
  ras_out_t          res_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Controller and resize policy.
  ras_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Stack storage.
  ras_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register.
  ras_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/ras_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_ram
// Generic synchronous RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ras_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ras_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_ctrl
// Stack controller: holds the count, capacity, peak and resize counters and
// a copy of the top word, applies the resize policy, drives the stack
// memory and builds one result item per input item.
// ----------------------------------------------------------------------------
module ras_ctrl
  import ras_pkg::*;
#(
  parameter int DEPTH = RAS_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         cfg_data_i,
  // Input items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  ras_in_t                  in_data_i,
  // Finished result towards the output register
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output ras_out_t                 res_data_o,
  // Stack memory
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [DATA_W-1:0]        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [DATA_W-1:0]        mem_rdata_i
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = ($clog2(DEPTH + 1) > CNT_OUT_W) ? $clog2(DEPTH + 1) : CNT_OUT_W;

  ras_state_e state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    cap_q, cap_d;
  logic [CNT_W-1:0]    peak_q, peak_d;
  logic [RESIZE_W-1:0] resize_q, resize_d;
  logic [DATA_W-1:0]   top_q, top_d;
  ras_out_t            res_q, res_d;

  logic               cfg_fire;
  logic               in_fire;
  logic               is_pop;
  logic               full;
  logic [CNT_W+2:0]   cap_x7;
  logic [CNT_W:0]     grow_raw;
  logic [CNT_W-1:0]   grow_cap;
  logic               grow_ev;
  logic               shrink_ev;
  logic               resize_ev;
  logic [CNT_W-1:0]   new_cap;
  logic [CNT_W-1:0]   new_peak;
  logic [RESIZE_W-1:0] new_resize;
  logic               push_ok;
  logic [CNT_W-1:0]   cfg_ext;
  logic [CNT_W-1:0]   cfg_cap;
  logic [CNT_W-1:0]   rd_idx;

  // Handshakes: the controller takes work only between items.
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_pop      = (in_data_i.command == CMD_POP);

  // Growth target: floor(cap * 7 / 4), limited to the physical depth.
  assign full     = (count_q == cap_q);
  assign cap_x7   = {cap_q, 3'b000} - {3'b000, cap_q};
  assign grow_raw = cap_x7[CNT_W+2:2];
  assign grow_cap = (grow_raw > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : grow_raw[CNT_W-1:0];
  assign grow_ev  = full && (grow_cap != cap_q);

  // Shrink when under half full, after a first resize and above the floor.
  assign shrink_ev = !full && ({count_q, 1'b0} < {1'b0, cap_q}) &&
                     (resize_q != '0) && (cap_q > CNT_W'(SHRINK_FLOOR));

  // A push only grows; a pop on a non-empty stack may grow or shrink.
  assign resize_ev  = is_pop ? ((count_q != '0) && (grow_ev || shrink_ev)) : grow_ev;
  assign new_cap    = resize_ev ? (grow_ev ? grow_cap : (cap_q >> 1)) : cap_q;
  assign new_peak   = (resize_ev && (peak_q < new_cap)) ? new_cap : peak_q;
  assign new_resize = (resize_ev && (resize_q != '1)) ? resize_q + RESIZE_W'(1) : resize_q;
  assign push_ok    = (count_q < new_cap);

  // Configured capacity, clamped to the legal range.
  assign cfg_ext = CNT_W'(cfg_data_i);
  assign cfg_cap = (cfg_ext < CNT_W'(MIN_CAPACITY)) ? CNT_W'(MIN_CAPACITY) :
                   (cfg_ext > CNT_W'(DEPTH))        ? CNT_W'(DEPTH)        : cfg_ext;

  // Memory accesses: a push writes the new top entry, a pop that leaves
  // elements behind reads the entry below the cached top.
  assign rd_idx      = count_q - CNT_W'(2);
  assign mem_we_o    = in_fire && !is_pop && push_ok;
  assign mem_waddr_o = count_q[AW-1:0];
  assign mem_wdata_o = in_data_i.value;
  assign mem_re_o    = in_fire && is_pop && (count_q >= CNT_W'(2));
  assign mem_raddr_o = rd_idx[AW-1:0];

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cap_q    <= CNT_W'(RESET_CAPACITY);
      peak_q   <= '0;
      resize_q <= '0;
      top_q    <= EMPTY_MARK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cap_q    <= cap_d;
      peak_q   <= peak_d;
      resize_q <= resize_d;
      top_q    <= top_d;
    end
  end

  // Result under construction.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Next state, stack update and result assembly.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cap_d    = cap_q;
    peak_d   = peak_q;
    resize_d = resize_q;
    top_d    = top_q;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          count_d  = '0;
          cap_d    = cfg_cap;
          peak_d   = '0;
          resize_d = '0;
          top_d    = EMPTY_MARK;
        end else if (in_fire) begin
          cap_d    = new_cap;
          peak_d   = new_peak;
          resize_d = new_resize;
          state_d  = ST_DONE;
          res_d.popped_value = '0;
          res_d.ok           = 1'b0;
          if (!is_pop) begin
            if (push_ok) begin
              count_d  = count_q + CNT_W'(1);
              top_d    = in_data_i.value;
              res_d.ok = 1'b1;
            end
          end else if (count_q == '0) begin
            res_d.popped_value = EMPTY_MARK;
          end else begin
            count_d            = count_q - CNT_W'(1);
            res_d.ok           = 1'b1;
            res_d.popped_value = top_q;
            if (count_q == CNT_W'(1)) begin
              top_d = EMPTY_MARK;
            end else begin
              state_d = ST_READ;
            end
          end
          res_d.top_value     = top_d;
          res_d.item_count    = count_d[CNT_OUT_W-1:0];
          res_d.capacity      = cap_d[CNT_OUT_W-1:0];
          res_d.peak_capacity = peak_d[CNT_OUT_W-1:0];
          res_d.resize_count  = resize_d;
          res_d.is_empty      = (count_d == '0);
          res_d.is_full       = (count_d == cap_d);
        end
      end
      ST_READ: begin
        // The word below the popped one becomes the new top.
        top_d           = mem_rdata_i;
        res_d.top_value = mem_rdata_i;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = (state_q == ST_DONE);
  assign res_data_o  = res_q;

  // The count never passes the logical capacity.
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("element count exceeds logical capacity");

  // The capacity stays within the legal range.
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q >= CNT_W'(MIN_CAPACITY)) && (cap_q <= CNT_W'(DEPTH)))
    else $error("logical capacity out of range");

  // No peak is recorded before the first resize.
  a_peak_after_resize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resize_q == '0) |-> (peak_q == '0))
    else $error("peak capacity set without a resize");

  // A pop that leaves elements behind waits for the memory read.
  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_pop && (count_q >= CNT_W'(2))) |=> (state_q == ST_READ))
    else $error("pop did not wait for the next top word");

  // A push never writes beyond the logical capacity.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (count_q < new_cap))
    else $error("stack write beyond capacity");

endmodule

// ===== rtl/core/ras_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_obuf
// Output register: holds one finished result item so that the controller
// can take the next input item while the result waits to be taken.
// ----------------------------------------------------------------------------
module ras_obuf
  import ras_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ras_out_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ras_out_t out_data_o
);

  logic     valid_q, valid_d;
  ras_out_t data_q;

  // The register is free when empty or when its item leaves this cycle.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
